// File: sv/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types, constants and codes for the Bloom filter insert/query unit.
// ----------------------------------------------------------------------------
package bfiq_pkg;

  // Filter store geometry
  localparam int FilterBytes = 4096;
  localparam int AddrW       = $clog2(FilterBytes);

  // Configuration register widths
  localparam int ProbeW  = 8;
  localparam int SizeW   = 13;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = SizeW;

  // Bit count of the filter (size * 8) and the remainder width
  localparam int DivW = SizeW + 3;

  // Hash constants
  localparam int           HashW     = 32;
  localparam logic [31:0]  HashSeed  = 32'h9747_B28C;
  localparam logic [31:0]  HashMul   = 32'h5BD1_E995;
  localparam int           MixShift  = 15;
  localparam int           DeltaRot  = 17;
  localparam int           MaxProbes = 30;
  localparam int           CntW      = $clog2(MaxProbes + 1);

  // Reset values of the configuration registers
  localparam logic [ProbeW-1:0] ProbeCountRst = ProbeW'(6);
  localparam logic [SizeW-1:0]  FilterSizeRst = SizeW'(FilterBytes);

  // Request op codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROBE_COUNT = 1'b0,
    CFG_FILTER_SIZE = 1'b1
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX,
    ST_PREP,
    ST_DIV,
    ST_CHK,
    ST_DONE
  } state_t;

  // Input request payload
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  key_byte;
    logic [15:0] key_length;
    logic        key_first;
    logic        key_last;
  } bfiq_in_t;

  // Result payload
  typedef struct packed {
    logic maybe_present;
    logic config_error;
  } bfiq_out_t;

  // Remainder unit status towards the sequencer
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } bfiq_mod_res_t;

endpackage

// File: sv/bfiq_ram.sv
// ----------------------------------------------------------------------------
// bfiq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/bfiq_mod_unit.sv
// ----------------------------------------------------------------------------
// bfiq_mod_unit
// Bit-serial remainder unit: 32-bit hash modulo the filter bit count,
// one dividend bit per cycle (restoring).
// ----------------------------------------------------------------------------
module bfiq_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bfiq_pkg::HashW-1:0]     dividend,
  input  logic [bfiq_pkg::DivW-1:0]      divisor,
  output bfiq_pkg::bfiq_mod_res_t        res
);
  import bfiq_pkg::*;

  localparam int StepW = $clog2(HashW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic [HashW-1:0] dvd_r, dvd_nxt;
  logic [DivW-1:0]  dvs_r, dvs_nxt;
  logic [DivW-1:0]  rem_r, rem_nxt;
  logic [DivW:0]    trial;
  logic [DivW:0]    dvs_ext;

  // One restoring step per cycle
  always_comb begin
    trial    = {rem_r, dvd_r[HashW-1]};
    dvs_ext  = {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= dvs_ext) begin
        rem_nxt = DivW'(trial - dvs_ext);
      end else begin
        rem_nxt = trial[DivW-1:0];
      end
      dvd_nxt = {dvd_r[HashW-2:0], 1'b0};
      cnt_nxt = cnt_r + StepW'(1);
      if (cnt_r == StepW'(HashW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

// File: sv/bloom_filter_insert_query_unit.sv
// Key bytes: each is accepted, then goes through one 32x32 multiply-and-mix (ST_MIX); empty-key bytes skip the mix.
// Last byte: a set-up state, then per probe the remainder steps, store read and check/update,
//   then the result register is loaded, later while one is unread; a bad configuration skips the probes.
// Clear request: all 4096 store bytes are zeroed, one store byte per cycle through the write port.
// Reset is synchronous, active low; afterwards the same clearing pass
//   runs and in_ready stays low until it ends. Configuration writes are taken always.
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_unit
// Bloom filter insert/query engine with double hashing over a byte store.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bfiq_pkg::bfiq_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bfiq_pkg::bfiq_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [bfiq_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bfiq_pkg::CfgW-1:0]         cfg_wdata
);
  import bfiq_pkg::*;

  state_t              state_r, state_nxt;
  logic [HashW-1:0]    hash_r, hash_nxt;
  logic                empty_r, empty_nxt;
  logic [HashW-1:0]    mix_in_r, mix_in_nxt;
  logic                last_r, last_nxt;
  logic                query_r, query_nxt;
  logic [HashW-1:0]    probe_h_r, probe_h_nxt;
  logic [HashW-1:0]    delta_r, delta_nxt;
  logic [CntW-1:0]     left_r, left_nxt;
  logic                maybe_r, maybe_nxt;
  logic                err_r, err_nxt;
  logic [AddrW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  bfiq_out_t           out_data_r, out_data_nxt;
  logic [ProbeW-1:0]   probe_count_r;
  logic [SizeW-1:0]    filter_size_r;

  logic                accept;
  logic [HashW-1:0]    seed_h;
  logic                seed_empty;
  logic [2*HashW-1:0]  product;
  logic [HashW-1:0]    prod_lo;
  logic [SizeW-1:0]    size_sat;
  logic [DivW-1:0]     bit_count;
  logic                cfg_bad;

  logic                mod_start;
  logic [HashW-1:0]    mod_dividend;
  bfiq_mod_res_t       mod_res;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [7:0]          ram_wdata;
  logic [AddrW-1:0]    ram_raddr;
  logic [7:0]          ram_rdata;
  logic [7:0]          bit_mask;
  logic                bit_hit;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Seed on the first byte of a key, otherwise carry on
  assign seed_h     = in_data.key_first ? (HashSeed ^ HashW'(in_data.key_length)) : hash_r;
  assign seed_empty = in_data.key_first ? (in_data.key_length == 16'd0) : empty_r;

  // Multiply stage of the byte mix
  assign product = mix_in_r * HashMul;
  assign prod_lo = product[HashW-1:0];

  // Effective size and validity of the configuration
  assign size_sat  = (filter_size_r > SizeW'(FilterBytes)) ? SizeW'(FilterBytes)
                                                           : filter_size_r;
  assign bit_count = {size_sat, 3'b000};
  assign cfg_bad   = (probe_count_r == '0) || (probe_count_r > ProbeW'(MaxProbes))
                     || (size_sat == '0);

  // Probe location from the remainder
  assign ram_raddr = mod_res.rem[AddrW+2:3];
  assign bit_mask  = 8'd1 << mod_res.rem[2:0];
  assign bit_hit   = |(ram_rdata & bit_mask);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    empty_nxt     = empty_r;
    mix_in_nxt    = mix_in_r;
    last_nxt      = last_r;
    query_nxt     = query_r;
    probe_h_nxt   = probe_h_r;
    delta_nxt     = delta_r;
    left_nxt      = left_r;
    maybe_nxt     = maybe_r;
    err_nxt       = err_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mod_start     = 1'b0;
    mod_dividend  = probe_h_r;
    ram_we        = 1'b0;
    ram_waddr     = ram_raddr;
    ram_wdata     = ram_rdata | bit_mask;

    // Result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AddrW'(1);
        if (clr_cnt_r == AddrW'(FilterBytes - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_CLEAR) begin
            clr_cnt_nxt = '0;
            state_nxt   = ST_CLEAR;
          end else if (in_data.op == OP_INSERT || in_data.op == OP_QUERY) begin
            empty_nxt = seed_empty;
            last_nxt  = in_data.key_last;
            query_nxt = (in_data.op == OP_QUERY);
            if (seed_empty) begin
              hash_nxt  = seed_h;
              state_nxt = in_data.key_last ? ST_PREP : ST_IDLE;
            end else begin
              hash_nxt   = seed_h;
              mix_in_nxt = seed_h ^ HashW'(in_data.key_byte);
              state_nxt  = ST_MIX;
            end
          end
        end
      end
      ST_MIX: begin
        hash_nxt  = prod_lo ^ (prod_lo >> MixShift);
        state_nxt = last_r ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        if (cfg_bad) begin
          maybe_nxt = query_r;
          err_nxt   = !query_r;
          state_nxt = ST_DONE;
        end else begin
          maybe_nxt    = query_r;
          err_nxt      = 1'b0;
          probe_h_nxt  = hash_r;
          delta_nxt    = {hash_r[DeltaRot-1:0], hash_r[HashW-1:DeltaRot]};
          left_nxt     = probe_count_r[CntW-1:0];
          mod_start    = 1'b1;
          mod_dividend = hash_r;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        // Remainder ready: the store read is issued at its address this cycle
        if (mod_res.done) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!query_r) begin
          ram_we = 1'b1;
        end
        if (query_r && !bit_hit) begin
          maybe_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else if (left_r == CntW'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          probe_h_nxt  = probe_h_r + delta_r;
          mod_dividend = probe_h_r + delta_r;
          mod_start    = 1'b1;
          left_nxt     = left_r - CntW'(1);
          state_nxt    = ST_DIV;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.maybe_present = maybe_r;
          out_data_nxt.config_error  = err_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and model-visible hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      hash_r      <= '0;
      empty_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hash_r      <= hash_nxt;
      empty_r     <= empty_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    mix_in_r   <= mix_in_nxt;
    last_r     <= last_nxt;
    query_r    <= query_nxt;
    probe_h_r  <= probe_h_nxt;
    delta_r    <= delta_nxt;
    left_r     <= left_nxt;
    maybe_r    <= maybe_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_count_r <= ProbeCountRst;
      filter_size_r <= FilterSizeRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROBE_COUNT: probe_count_r <= cfg_wdata[ProbeW-1:0];
        CFG_FILTER_SIZE: filter_size_r <= cfg_wdata[SizeW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Shared remainder unit
  bfiq_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (bit_count),
    .res      (mod_res)
  );

  // Filter store
  bfiq_ram #(
    .WIDTH (8),
    .DEPTH (FilterBytes)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/bfiq_checker.sv
// ----------------------------------------------------------------------------
// bfiq_checker
// Port-level checks on the Bloom filter unit, bound to the top level.
// ----------------------------------------------------------------------------
module bfiq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input bfiq_pkg::bfiq_in_t           in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input bfiq_pkg::bfiq_out_t          out_data
);
  import bfiq_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A result never carries both a maybe answer and an error flag
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.maybe_present && out_data.config_error))
    else $error("maybe_present and config_error both set");

  // Store is swept after reset before any request is taken
  a_rst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("request taken during the reset clearing pass");

  // A clear request blocks further requests while the sweep runs
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_CLEAR) |=> !in_ready)
    else $error("request taken straight after a clear");

  // The last byte of a key starts work that blocks the input
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.key_last &&
    (in_data.op == OP_INSERT || in_data.op == OP_QUERY) |=> !in_ready)
    else $error("request taken straight after the last byte of a key");

endmodule

bind bloom_filter_insert_query_unit bfiq_checker u_bfiq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: bench/bloom_answer_checker.sv
// ----------------------------------------------------------------------------
// bloom_answer_checker
// Watches the request, result and configuration ports of the Bloom filter
// unit. It keeps its own copy of the bit store, running hash and registers,
// predicts the answer of every key that ends, and compares each result
// against the oldest answer still due.
// ----------------------------------------------------------------------------
module bloom_answer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  bfiq_pkg::bfiq_in_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  bfiq_pkg::bfiq_out_t          out_data,
  input  logic                         cfg_we,
  input  logic [bfiq_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bfiq_pkg::CfgW-1:0]    cfg_wdata,
  output int                           mismatch_count,
  output int                           answers_due
);
  import bfiq_pkg::*;

  // Predicted state of the unit
  logic [7:0]        bit_store [FilterBytes];
  logic [HashW-1:0]  key_hash;
  logic              key_empty;
  logic [ProbeW-1:0] probe_count;
  logic [SizeW-1:0]  size_bytes;

  bfiq_out_t         expected_answers [$];
  bfiq_out_t         want;
  int                faults = 0;

  // Count a fault; only the first few are worth printing
  task automatic note_fault(string msg);
    faults++;
    if (faults <= 10)
      $display("checker: %s at %0t", msg, $time);
  endtask

  // Advance the hash with one request and, at the end of a key, work out its answer
  task automatic predict_answer(bfiq_in_t req);
    logic [HashW-1:0] h;
    logic [HashW-1:0] step;
    logic [31:0]      nbits;
    logic [31:0]      bitpos;
    logic [SizeW-1:0] used;
    logic             bad;
    logic             hit;
    bfiq_out_t        ans;
    case (req.op)
      OP_CLEAR: begin
        foreach (bit_store[i]) bit_store[i] = '0;
      end
      OP_INSERT, OP_QUERY: begin
        if (req.key_first) begin
          key_hash  = HashSeed ^ HashW'(req.key_length);
          key_empty = (req.key_length == '0);
        end
        // empty key: bytes leave the seed untouched
        if (!key_empty) begin
          h        = (key_hash ^ HashW'(req.key_byte)) * HashMul;
          key_hash = h ^ (h >> MixShift);
        end
        if (req.key_last) begin
          used = (size_bytes > SizeW'(FilterBytes)) ? SizeW'(FilterBytes) : size_bytes;
          bad  = (probe_count == '0) || (probe_count > MaxProbes) || (used == '0);
          ans  = '0;
          if (bad) begin
            ans.maybe_present = (req.op == OP_QUERY);
            ans.config_error  = (req.op == OP_INSERT);
          end else begin
            nbits = {16'h0000, used, 3'b000};
            h     = key_hash;
            step  = {h[DeltaRot-1:0], h[HashW-1:DeltaRot]};
            hit   = 1'b1;
            // query stops at the first clear bit
            for (int i = 0; i < probe_count && hit; i++) begin
              bitpos = h % nbits;
              if (req.op == OP_INSERT)
                bit_store[bitpos >> 3][bitpos[2:0]] = 1'b1;
              else if (!bit_store[bitpos >> 3][bitpos[2:0]])
                hit = 1'b0;
              h = h + step;
            end
            ans.maybe_present = (req.op == OP_QUERY) && hit;
          end
          expected_answers.insert(expected_answers.size(), ans);
        end
      end
      default: ;
    endcase
  endtask

  // Results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (bit_store[i]) bit_store[i] = '0;
      key_hash    = '0;
      key_empty   = 1'b0;
      probe_count = ProbeCountRst;
      size_bytes  = FilterSizeRst;
      expected_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          note_fault($sformatf("result maybe_present=%0b config_error=%0b with none due",
                               out_data.maybe_present, out_data.config_error));
        end else begin
          want = expected_answers.pop_front();
          if (out_data.maybe_present !== want.maybe_present)
            note_fault($sformatf("maybe_present expected %0b, got %0b",
                                 want.maybe_present, out_data.maybe_present));
          if (out_data.config_error !== want.config_error)
            note_fault($sformatf("config_error expected %0b, got %0b",
                                 want.config_error, out_data.config_error));
        end
      end
      if (in_valid && in_ready)
        predict_answer(in_data);
      if (cfg_we) begin
        if (cfg_index == CFG_PROBE_COUNT)
          probe_count = cfg_wdata[ProbeW-1:0];
        else
          size_bytes = cfg_wdata[SizeW-1:0];
      end
    end
    mismatch_count <= faults;
    answers_due    <= expected_answers.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives key streams into the Bloom filter unit: a directed opening over the
// special cases, then random keys drawn from a small pool so that queries hit,
// across several probe count and filter size settings including invalid ones.
// Both handshakes idle at random; the checker beside the unit does the scoring.
// ----------------------------------------------------------------------------
module testbench;
  import bfiq_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam int         SettleCycles = 4200;  // covers a clear in flight
  localparam int         PoolKeys     = 16;
  localparam int         MaxKeyBytes  = 8;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bfiq_in_t           in_data;
  logic               out_valid;
  logic               out_ready;
  bfiq_out_t          out_data;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_wdata;
  int                 mismatch_count;
  int                 answers_due;

  bit                 calm;           // no idling on either side while set
  int                 requests_sent;
  logic [7:0]         key_buf [MaxKeyBytes];
  logic [7:0]         pool_bytes [PoolKeys][MaxKeyBytes];
  int                 pool_n [PoolKeys];
  logic [15:0]        pool_len [PoolKeys];

  bloom_filter_insert_query_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bloom_answer_checker answer_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .answers_due    (answers_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #100_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Result side: random stall on each result, held low until it shows
  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (out_valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic bfiq_in_t make_req(logic [1:0] op, logic [7:0] kb, logic [15:0] len,
                                        logic first, logic last);
    bfiq_in_t r;
    r.op         = op;
    r.key_byte   = kb;
    r.key_length = len;
    r.key_first  = first;
    r.key_last   = last;
    return r;
  endfunction

  // One request through the valid/ready handshake, after a random gap
  task automatic push_request(bfiq_in_t req);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    requests_sent++;
  endtask

  // Key in key_buf as n requests; stray mixes ops on all but the last byte
  task automatic send_key(logic [1:0] op, logic [15:0] len, int n, bit stray);
    logic [1:0] this_op;
    for (int i = 0; i < n; i++) begin
      this_op = (stray && i != n - 1) ? ($urandom_range(0, 1) ? OP_QUERY : OP_INSERT) : op;
      push_request(make_req(this_op, key_buf[i], (i == 0) ? len : 16'($urandom),
                            i == 0, i == n - 1));
    end
  endtask

  // Random key into key_buf: mostly short, now and then empty or with an odd length
  task automatic fill_key(output int n, output logic [15:0] len);
    int pick;
    n    = ($urandom_range(0, 15) == 0) ? MaxKeyBytes : $urandom_range(1, 5);
    pick = $urandom_range(0, 9);
    len  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'($urandom) : 16'(n);
    for (int i = 0; i < MaxKeyBytes; i++) key_buf[i] = 8'($urandom);
  endtask

  task automatic run_traffic(int quota);
    int          stop;
    int          pick;
    int          slot;
    int          n;
    logic [1:0]  op;
    logic [15:0] len;
    stop = requests_sent + quota;
    while (requests_sent < stop) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise: stray bytes, broken keys, unused op
        op = ($urandom_range(0, 2) == 0) ? OpUnused
                                         : ($urandom_range(0, 1) ? OP_QUERY : OP_INSERT);
        push_request(make_req(op, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)));
      end else if (pick == 8) begin
        push_request(make_req(OP_CLEAR, 8'($urandom), 16'($urandom),
                              1'($urandom), 1'($urandom)));
      end else begin
        op   = $urandom_range(0, 1) ? OP_QUERY : OP_INSERT;
        slot = $urandom_range(0, PoolKeys - 1);
        if (op == OP_QUERY && $urandom_range(0, 3) == 0) begin
          fill_key(n, len);
        end else begin
          if (op == OP_INSERT && $urandom_range(0, 2) == 0) begin
            fill_key(pool_n[slot], pool_len[slot]);
            for (int i = 0; i < MaxKeyBytes; i++) pool_bytes[slot][i] = key_buf[i];
          end
          for (int i = 0; i < MaxKeyBytes; i++) key_buf[i] = pool_bytes[slot][i];
          n   = pool_n[slot];
          len = pool_len[slot];
        end
        send_key(op, len, n, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Drain all answers, then let any clear or trailing byte finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_config(logic [ProbeW-1:0] probes, logic [SizeW-1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROBE_COUNT;
    cfg_wdata <= {(CfgW - ProbeW)'($urandom), probes};  // upper bits are dropped
    @(posedge clk);
    cfg_index <= CFG_FILTER_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic reconfigure(logic [ProbeW-1:0] probes, logic [SizeW-1:0] size);
    settle();
    set_config(probes, size);
  endtask

  // Stimulus and verdict
  initial begin
    int          n;
    logic [15:0] len;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PROBE_COUNT;
    cfg_wdata <= '0;
    calm          = 1'b0;
    requests_sent = 0;
    for (int s = 0; s < PoolKeys; s++) begin
      fill_key(n, len);
      pool_n[s]   = n;
      pool_len[s] = len;
      for (int i = 0; i < MaxKeyBytes; i++) pool_bytes[s][i] = key_buf[i];
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(ProbeCountRst, FilterSizeRst);

    // unknown key on an empty store, then insert it and read it back
    key_buf[0] = 8'h00;
    key_buf[1] = 8'hFF;
    send_key(OP_QUERY, 16'd2, 2, 1'b0);
    send_key(OP_INSERT, 16'd2, 2, 1'b0);
    send_key(OP_QUERY, 16'd2, 2, 1'b0);
    // empty key: bytes ignored, so a different byte still matches
    push_request(make_req(OP_INSERT, 8'hFF, 16'h0000, 1'b1, 1'b1));
    push_request(make_req(OP_QUERY, 8'h00, 16'h0000, 1'b1, 1'b1));
    // longest length field
    push_request(make_req(OP_INSERT, 8'h00, 16'hFFFF, 1'b1, 1'b1));
    // more bytes than the length says
    key_buf[0] = 8'h5A;
    key_buf[1] = 8'hA5;
    key_buf[2] = 8'h3C;
    send_key(OP_QUERY, 16'd1, 3, 1'b0);
    // no first item: the byte carries on from the running hash
    push_request(make_req(OP_QUERY, 8'h81, 16'h1234, 1'b0, 1'b1));
    // mixed ops, the last byte makes it a query
    push_request(make_req(OP_INSERT, 8'h11, 16'd3, 1'b1, 1'b0));
    push_request(make_req(OP_INSERT, 8'h22, 16'hFFFF, 1'b0, 1'b0));
    push_request(make_req(OP_QUERY, 8'h33, 16'h0000, 1'b0, 1'b1));
    // unused op code with everything set
    push_request(make_req(OpUnused, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
    // clear with stray flags, then the first key reads absent again
    push_request(make_req(OP_CLEAR, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
    key_buf[0] = 8'h00;
    key_buf[1] = 8'hFF;
    send_key(OP_QUERY, 16'd2, 2, 1'b0);

    // random keys over a spread of settings, valid and invalid
    run_traffic(115);
    reconfigure(8'd30, 13'd8191);
    run_traffic(115);
    reconfigure(8'd1, 13'd1);
    run_traffic(115);
    reconfigure(8'd0, 13'd4096);
    run_traffic(115);
    reconfigure(8'd31, 13'd64);
    run_traffic(115);
    reconfigure(8'd255, 13'd0);
    run_traffic(115);
    reconfigure(ProbeW'($urandom_range(1, MaxProbes)), SizeW'($urandom_range(1, 8191)));
    run_traffic(115);
    reconfigure(ProbeW'($urandom_range(1, MaxProbes)), SizeW'($urandom_range(1, 8191)));
    run_traffic(115);

    settle();
    if (mismatch_count == 0 && answers_due == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: files.f
sv/bfiq_pkg.sv
sv/bfiq_ram.sv
sv/bfiq_mod_unit.sv
sv/bloom_filter_insert_query_unit.sv
sv/bfiq_checker.sv
bench/bloom_answer_checker.sv
bench/testbench.sv
